// File: hdl/sliding_window_widest_range_macros.svh
// Assertion macros shared by the sliding window range block
`ifndef SLIDING_WINDOW_WIDEST_RANGE_MACROS_SVH
`define SLIDING_WINDOW_WIDEST_RANGE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high
`define SWWR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high
`define SWWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/swwr_pkg.sv
// Types and constants shared by the sliding window range block
`timescale 1ns / 1ps
`default_nettype none
package swwr_pkg;

  localparam int SAMPLE_W = 32;
  localparam int START_W  = 16;
  localparam int LEN_W    = 7;
  localparam int ODATA_W  = 48;
  localparam int OUSER_W  = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic scan;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/swwr_ctrl.sv
// Sequencer for the sliding window range block
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_widest_range_macros.svh"
module swwr_ctrl
  import swwr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `SWWR_ASSERT_NEXT(a_take_starts_scan, cmd.take, state == ST_SCAN, "take did not start a scan")
  `SWWR_ASSERT_SAME(a_busy_no_ready, state != ST_IDLE, !s_tready, "ready while item in flight")
  `SWWR_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd), "more than one command at once")

endmodule
`default_nettype wire

// File: hdl/swwr_datapath.sv
// Window store, min/max scan, best-range registers and output register
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_widest_range_macros.svh"
module swwr_datapath
  import swwr_pkg::*;
#(
  parameter int WINDOW_MAX = 64,
  parameter int SERIES_MAX = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [LEN_W-1:0]    window_len,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                restart,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [ODATA_W-1:0]  m_tdata,
  output logic [OUSER_W-1:0]  m_tuser
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(SERIES_MAX);

  logic [SAMPLE_W-1:0] mem [WINDOW_MAX];
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_vld;
  logic [AW-1:0]       wp, wp_next, rp;
  logic [FW-1:0]       left, fill, fill_next, len_eff;
  logic [PW-1:0]       pos, pos_cur, pos_next, start_cand, best_start;
  logic [SAMPLE_W-1:0] mx, mn, best_range, range_cur;
  logic                full, full_next, found, issue;
  logic [31:0]         len_wide, len_m1, pos_wide, start_wide, bs_ext;

  // clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (window_len == '0) begin
      len_wide = 32'd1;
    end else if ({25'd0, window_len} > 32'(WINDOW_MAX)) begin
      len_wide = 32'(WINDOW_MAX);
    end else begin
      len_wide = {25'd0, window_len};
    end
  end
  assign len_eff = len_wide[FW-1:0];
  assign len_m1  = len_wide - 32'd1;

  assign wp_next   = (wp == AW'(WINDOW_MAX - 1)) ? '0 : wp + AW'(1);
  assign fill_next = restart ? FW'(1) :
                     (fill < FW'(WINDOW_MAX)) ? fill + FW'(1) : fill;
  assign full_next = (fill_next >= len_eff);
  assign pos_cur   = restart ? '0 : pos;
  assign pos_next  = (pos_cur != PW'(SERIES_MAX - 1)) ? pos_cur + PW'(1) : pos_cur;
  assign pos_wide  = 32'(pos_cur);
  assign start_wide = (pos_wide >= len_m1) ? pos_wide - len_m1 : 32'd0;

  assign issue     = cmd.scan && (left != '0);
  assign range_cur = mx - mn;
  assign bs_ext    = 32'(best_start);

  assign sts.scan_done = (left == '0) && !rd_vld;
  assign sts.out_busy  = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wp_next] <= sample;
    end
    if (issue) begin
      rd_data <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      left       <= '0;
      fill       <= '0;
      pos        <= '0;
      full       <= 1'b0;
      rd_vld     <= 1'b0;
      best_range <= '0;
      best_start <= '0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.take) begin
        wp   <= wp_next;
        rp   <= wp;
        fill <= fill_next;
        pos  <= pos_next;
        full <= full_next;
        left <= full_next ? len_eff - FW'(1) : '0;
        if (restart) begin
          best_range <= '0;
          best_start <= '0;
          found      <= 1'b0;
        end
      end
      if (issue) begin
        left <= left - FW'(1);
        rp   <= (rp == '0) ? AW'(WINDOW_MAX - 1) : rp - AW'(1);
      end
      if (cmd.eval && full && (range_cur > best_range)) begin
        best_range <= range_cur;
        best_start <= start_cand;
        found      <= 1'b1;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mx         <= sample;
      mn         <= sample;
      start_cand <= start_wide[PW-1:0];
    end
    if (rd_vld) begin
      if (rd_data > mx) mx <= rd_data;
      if (rd_data < mn) mn <= rd_data;
    end
    if (cmd.load_out) begin
      m_tdata <= {bs_ext[START_W-1:0], best_range};
      m_tuser <= {full, found};
    end
  end

  `SWWR_ASSERT_SAME(a_found_nonzero, found, best_range != '0, "found with zero best range")
  `SWWR_ASSERT_SAME(a_start_clear, !found, best_start == '0, "start set while nothing found")
  `SWWR_ASSERT_SAME(a_fill_bound, 1'b1, fill <= FW'(WINDOW_MAX), "fill count past store depth")

endmodule
`default_nettype wire

// File: hdl/sliding_window_widest_range.sv
// Top level of the sliding window widest range block
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s       | in  | s_tvalid/s_tready  | tdata[31:0] sample, tuser[0] restart
//  m       | out | m_tvalid/m_tready  | tdata[31:0] best_range, [47:32] best_start
//          |     |                    | tuser[0] found, tuser[1] window_full
//  cfg     | in  | cfg_valid/cfg_ready| cfg_data[6:0] window_len
//
// One beat is taken while the sequencer is idle and then passes the scan,
// evaluate and done states: the scan reads one stored sample per cycle through
// the single read port of the window store and drains the read pipeline, then
// evaluate updates the best range and the done state loads the output
// register. A new beat is taken once the previous result sits in the output
// register, even while m_tready is low; a result still waiting there holds
// the sequencer before its load, and the input stalls with it. rst is
// synchronous and clears the sequencer, counters and best-range state;
// window_len returns to 8. The store itself holds stale data after reset and
// is never read before it is written in the current series.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_widest_range
  import swwr_pkg::*;
#(
  parameter int WINDOW_MAX = 64,
  parameter int SERIES_MAX = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic [0:0]          s_tuser,   // [0] restart
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [ODATA_W-1:0]  m_tdata,   // [31:0] best_range, [47:32] best_start
  output logic [OUSER_W-1:0]  m_tuser,   // [0] found, [1] window_full
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEN_W-1:0]    cfg_data   // [6:0] window_len
);

  logic [LEN_W-1:0] window_len;
  cmd_t             cmd;
  sts_t             sts;

  // writes are to arrive only while idle; the block does not enforce this and always takes them
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= LEN_W'(8);
    end else if (cfg_valid) begin
      window_len <= cfg_data;
    end
  end

  swwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  swwr_datapath #(
    .WINDOW_MAX (WINDOW_MAX),
    .SERIES_MAX (SERIES_MAX)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .window_len (window_len),
    .sample     (s_tdata),
    .restart    (s_tuser[0]),
    .cmd        (cmd),
    .sts        (sts),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
`default_nettype wire
